@@ src/state_variable_filter_stereo_unit_defines.svh @@
`ifndef STATE_VARIABLE_FILTER_STEREO_UNIT_DEFINES_SVH
`define STATE_VARIABLE_FILTER_STEREO_UNIT_DEFINES_SVH
// Same-cycle check on the block clock, masked while in reset.
`define SVFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle check on the block clock, masked while in reset.
`define SVFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ src/svfs_pkg.sv @@
`timescale 1ns / 1ps
package svfs_pkg;
   localparam int DW     = 42;   // lane datapath width
   localparam int PW     = 54;   // lane product width
   localparam int OUTP_W = 33;   // filter tap after scaling down
   localparam int NUM_W  = 28;   // coefficient dividend
   localparam int FS_W   = 18;   // sample rate width
   localparam int ADDR_W = 5;

   localparam logic [12:0] F_SCALE    = 13'd6433;
   localparam logic [10:0] Q_BASE     = 11'd1536;
   localparam logic [13:0] CUT_STEP   = 14'd14000;
   localparam logic [10:0] RES_STEP   = 11'd1530;
   localparam logic [9:0]  F_MAX      = 10'd1023;
   localparam logic [18:0] TICK_RECIP = 19'd335545;   // ceil(2^26 / 200)
   localparam int          TICK_SHIFT = 26;

   localparam logic [1:0] MODE_SAMPLE  = 2'd0;
   localparam logic [1:0] MODE_IMPULSE = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] RESP_LOW   = 2'd0;
   localparam logic [1:0] RESP_HIGH  = 2'd1;
   localparam logic [1:0] RESP_BAND  = 2'd2;
   localparam logic [1:0] RESP_NOTCH = 2'd3;

   localparam logic [2:0] REG_VOLUME    = 3'd0;
   localparam logic [2:0] REG_CUTOFF    = 3'd1;
   localparam logic [2:0] REG_RESONANCE = 3'd2;
   localparam logic [2:0] REG_RESPONSE  = 3'd3;
   localparam logic [2:0] REG_SMOOTH    = 3'd4;
   localparam logic [2:0] REG_QUALITY   = 3'd5;
   localparam logic [2:0] REG_WET       = 3'd6;
   localparam logic [2:0] REG_RATE      = 3'd7;

   localparam logic signed [PW-1:0] S16_HI = PW'(32'sd32767);
   localparam logic signed [PW-1:0] S16_LO = PW'(-32'sd32768);
   localparam logic signed [PW-1:0] S32_HI = PW'(64'sd2147483647);
   localparam logic signed [PW-1:0] S32_LO = PW'(-64'sd2147483648);

   typedef enum logic [2:0] {
      T_IDLE, T_TICK, T_DIV, T_FMUL, T_START, T_RUN
   } top_state_type;

   typedef enum logic [4:0] {
      L_IDLE, L_P1, L_LOW1, L_HIGH1, L_P3, L_BAND1, L_P4, L_LOW2, L_HIGH2,
      L_P6, L_BAND2, L_OUT, L_WET, L_MIX, L_FIN, L_BYP, L_BYP2
   } lane_state_type;

   typedef struct packed {
      logic              hq;
      logic [1:0]        rtype;
      logic [9:0]        f;
      logic signed [11:0] q;
      logic [9:0]        wv;
      logic [8:0]        v2;
      logic [8:0]        vol;
      logic              bypass;
      logic              partial;
   } lane_ctl_type;

   typedef struct packed {
      logic              busy;
      logic signed [15:0] res;
   } lane_stat_type;

   // signed divide by 2^sh, rounding toward zero
   function automatic logic signed [PW-1:0] tdiv(input logic signed [PW-1:0] v,
                                                 input int unsigned sh);
      logic signed [PW-1:0] bias;
      bias = v[PW-1] ? $signed((PW'(1) << sh) - PW'(1)) : '0;
      return (v + bias) >>> sh;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
      if (v > S16_HI) return 16'sh7FFF;
      else if (v < S16_LO) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
      if (v > S32_HI) return 32'sh7FFFFFFF;
      else if (v < S32_LO) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage

@@ src/svfs_if.sv @@
`timescale 1ns / 1ps
interface svfs_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic signed [15:0] left_in;
   logic signed [15:0] right_in;
   logic [13:0]       impulse_cutoff;
   modport source (output valid, mode, left_in, right_in, impulse_cutoff, input ready);
   modport sink   (input valid, mode, left_in, right_in, impulse_cutoff, output ready);
endinterface

interface svfs_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] left_out;
   logic signed [15:0] right_out;
   logic              right_valid;
   modport source (output valid, left_out, right_out, right_valid, input ready);
   modport sink   (input valid, left_out, right_out, right_valid, output ready);
endinterface

@@ src/svfs_div.sv @@
`timescale 1ns / 1ps
module svfs_div import svfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [FS_W-1:0]  den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [FS_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [FS_W+1:0]  trial;

   // restoring divide, one quotient bit per cycle
   assign trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
         if (!trial[FS_W+1]) begin
            rem_in = trial[FS_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[FS_W-2:0], quo_ff[NUM_W-1]};
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule

@@ src/svfs_lane.sv @@
`timescale 1ns / 1ps
module svfs_lane import svfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              clear,
   input  lane_ctl_type      ctl,
   input  logic signed [15:0] x,
   output lane_stat_type     stat
);
   lane_state_type state_ff, state_in;
   lane_ctl_type   ctl_ff, ctl_in;
   logic signed [15:0]     x_ff, x_in, res_ff, res_in;
   logic signed [31:0]     d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic signed [DW-1:0]   low_ff, low_in, high_ff, high_in, band_ff, band_in;
   logic signed [DW-1:0]   s_low_ff, s_low_in, s_high_ff, s_high_in, s_band_ff, s_band_in;
   logic signed [OUTP_W-1:0] outp_ff, outp_in;
   logic signed [PW-1:0]   prod_ff, prod_in, sel_num, d3_new;
   logic signed [11:0]     mul_a;
   logic signed [DW-1:0]   mul_b, d1e, d2e, d3e, xs, dq;
   logic signed [11:0]     f_s;

   assign d1e = DW'(d1_ff);
   assign d2e = DW'(d2_ff);
   assign d3e = DW'(d3_ff);
   assign xs  = DW'(x_ff) <<< 5;
   assign dq  = DW'(tdiv(prod_ff, 10));
   assign f_s = $signed({2'b00, ctl_ff.f});
   assign prod_in = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE:  if (start) state_in = ctl.bypass ? L_BYP : L_P1;
         L_P1:    state_in = L_LOW1;
         L_LOW1:  state_in = L_HIGH1;
         L_HIGH1: state_in = L_P3;
         L_P3:    state_in = L_BAND1;
         L_BAND1: state_in = ctl_ff.hq ? L_P4 : L_OUT;
         L_P4:    state_in = L_LOW2;
         L_LOW2:  state_in = L_HIGH2;
         L_HIGH2: state_in = L_P6;
         L_P6:    state_in = L_BAND2;
         L_BAND2: state_in = L_OUT;
         L_OUT:   state_in = L_WET;
         L_WET:   state_in = L_MIX;
         L_MIX:   state_in = ctl_ff.partial ? L_FIN : L_IDLE;
         L_FIN:   state_in = L_IDLE;
         L_BYP:   state_in = L_BYP2;
         L_BYP2:  state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      ctl_in = ctl_ff;  x_in = x_ff;  res_in = res_ff;
      d1_in = d1_ff;  d2_in = d2_ff;  d3_in = d3_ff;
      low_in = low_ff;  high_in = high_ff;  band_in = band_ff;
      s_low_in = s_low_ff;  s_high_in = s_high_ff;  s_band_in = s_band_ff;
      outp_in = outp_ff;
      mul_a = '0;  mul_b = '0;
      sel_num = '0;  d3_new = PW'(d3_ff);
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               ctl_in = ctl;
               x_in   = x;
            end
            if (clear) begin
               d1_in = '0;  d2_in = '0;  d3_in = '0;
            end
         end
         L_P1: begin
            mul_a = f_s;  mul_b = d1e;
         end
         L_LOW1: begin
            low_in = d2e + dq;
            mul_a = ctl_ff.q;  mul_b = d1e;
         end
         L_HIGH1: high_in = xs - low_ff - dq;
         L_P3: begin
            mul_a = f_s;  mul_b = high_ff;
         end
         L_BAND1: band_in = dq + d1e;
         L_P4: begin
            mul_a = f_s;  mul_b = band_ff;
            s_low_in = low_ff;  s_high_in = high_ff;  s_band_in = band_ff;
         end
         L_LOW2: begin
            low_in = low_ff + dq;
            mul_a = ctl_ff.q;  mul_b = band_ff;
         end
         L_HIGH2: high_in = xs - low_ff - dq;
         L_P6: begin
            mul_a = f_s;  mul_b = high_ff;
         end
         L_BAND2: band_in = dq + band_ff;
         L_OUT: begin
            // HQ averages the stored tap with the first-pass tap
            unique case (ctl_ff.rtype)
               RESP_LOW:  sel_num = ctl_ff.hq ? PW'(d2e) + PW'(s_low_ff) : PW'(low_ff);
               RESP_HIGH: sel_num = ctl_ff.hq ? PW'(d3e) + PW'(s_high_ff) : PW'(high_ff);
               RESP_BAND: sel_num = ctl_ff.hq ? PW'(d1e) + PW'(s_band_ff) : PW'(band_ff);
               RESP_NOTCH: sel_num = ctl_ff.hq
                  ? PW'(d3e) + PW'(s_high_ff) + PW'(s_low_ff)
                  : PW'(high_ff) + PW'(low_ff);
               default: sel_num = '0;
            endcase
            if (ctl_ff.hq && ctl_ff.rtype == RESP_HIGH) d3_new = PW'(high_ff);
            else if (ctl_ff.hq && ctl_ff.rtype == RESP_NOTCH)
               d3_new = PW'(high_ff) + PW'(low_ff);
            outp_in = OUTP_W'(tdiv(sel_num, ctl_ff.hq ? 6 : 5));
            d1_in = sat32(PW'(band_ff));
            d2_in = sat32(PW'(low_ff));
            d3_in = sat32(d3_new);
         end
         L_WET: begin
            mul_a = $signed({2'b00, ctl_ff.wv});  mul_b = DW'(outp_ff);
         end
         L_MIX: begin
            res_in = sat16(tdiv(prod_ff, 8));
            mul_a = $signed({3'b000, ctl_ff.v2});  mul_b = DW'(x_ff);
         end
         L_FIN: res_in = sat16(PW'(res_ff) + tdiv(prod_ff, 8));
         L_BYP: begin
            mul_a = $signed({3'b000, ctl_ff.vol});  mul_b = DW'(x_ff);
         end
         L_BYP2: res_in = sat16(tdiv(prod_ff, 8));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         d1_ff <= '0;  d2_ff <= '0;  d3_ff <= '0;
      end else begin
         state_ff <= state_in;
         d1_ff <= d1_in;  d2_ff <= d2_in;  d3_ff <= d3_in;
      end
      ctl_ff <= ctl_in;  x_ff <= x_in;  res_ff <= res_in;
      low_ff <= low_in;  high_ff <= high_in;  band_ff <= band_in;
      s_low_ff <= s_low_in;  s_high_ff <= s_high_in;  s_band_ff <= s_band_in;
      outp_ff <= outp_in;  prod_ff <= prod_in;
   end

   // status
   always_comb begin
      stat.busy = (state_ff != L_IDLE);
      stat.res  = res_ff;
   end
endmodule

@@ src/state_variable_filter_stereo_unit.sv @@
// Sample item: after acceptance the cutoff runs through the 28-step divider, then each lane
// runs bypass, one LQ pass or two HQ passes on its per-lane shared multiplier, a partial mix
// adding a final step; a result still waiting in the output register holds the load back.
// A new item is accepted no earlier than the cycle after the last sample's result is loaded.
// Impulse, clear and unused items are taken while idle and give no result.
// Reset (synchronous, active high) loads register defaults, clears filter stores, resets smoothing.
`timescale 1ns / 1ps
`include "state_variable_filter_stereo_unit_defines.svh"
module state_variable_filter_stereo_unit import svfs_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic              clock,
   input  logic              reset,
   svfs_req_if.sink          req_ch,
   svfs_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   // config registers
   logic [8:0]  vol_tgt_ff, rate_ff, wet_ff;
   logic [13:0] cut_tgt_ff;
   logic [10:0] res_tgt_ff;
   logic [1:0]  rtype_ff, qm_ff;
   logic [17:0] sr_ff;
   logic        wr_en;
   logic [2:0]  wr_idx;

   // smoothing state
   logic [21:0] cut_ff, cut_in;
   logic [18:0] reso_ff, reso_in;
   logic [16:0] svol_ff, svol_in;
   logic [15:0] tick_cnt_ff, tick_cnt_in, cnt_next;

   // per-item latches
   top_state_type state_ff, state_in;
   lane_ctl_type  ctl_ff, ctl_in, lane_ctl;
   logic          mono_ff, mono_in;
   logic signed [15:0] xl_ff, xl_in, xr_ff, xr_in;
   logic [10:0]   tick_size_ff, tick_size_in;
   logic [40:0]   fprod_ff, fprod_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in, rv_ff, rv_in;
   logic signed [15:0] lo_ff, lo_in, ro_ff, ro_in;

   // control
   logic accept, is_sample, div_start, div_busy, lane_start, load_out;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [FS_W-1:0]  div_den;
   logic [13:0]      co;
   logic [8:0]       vol_now;
   logic [17:0]      wv_prod, v2_prod;
   logic [36:0]      ts_prod;
   logic [10:0]      ts_raw;
   logic             hq_now, mono_now;
   logic signed [24:0] cut_new, reso_new, svol_new;
   lane_stat_type    lane_stat [CHANNELS];

   function automatic logic signed [24:0] approach(input logic signed [24:0] cur,
                                                   input logic signed [24:0] tgt,
                                                   input logic signed [24:0] step);
      logic signed [24:0] lvl, n, tgt_sc;
      lvl = cur >>> 8;
      tgt_sc = tgt <<< 8;
      n = cur;
      if (lvl > tgt) begin
         n = cur - step;
         if (n < tgt_sc) n = tgt_sc;
      end else if (lvl < tgt) begin
         n = cur + step;
         if ((n >>> 8) > tgt) n = tgt_sc;
      end
      return n;
   endfunction

   // ---------------- register port ----------------
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = paddr[ADDR_W-1:2];

   always_comb begin
      unique case (wr_idx)
         REG_VOLUME:    prdata = 32'(vol_tgt_ff);
         REG_CUTOFF:    prdata = 32'(cut_tgt_ff);
         REG_RESONANCE: prdata = 32'(res_tgt_ff);
         REG_RESPONSE:  prdata = 32'(rtype_ff);
         REG_SMOOTH:    prdata = 32'(rate_ff);
         REG_QUALITY:   prdata = 32'(qm_ff);
         REG_WET:       prdata = 32'(wet_ff);
         REG_RATE:      prdata = 32'(sr_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_tgt_ff <= 9'd256;
         cut_tgt_ff <= CUT_STEP;
         res_tgt_ff <= '0;
         rtype_ff   <= RESP_LOW;
         rate_ff    <= 9'd256;
         qm_ff      <= '0;
         wet_ff     <= 9'd256;
         sr_ff      <= 18'd44100;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_VOLUME:    vol_tgt_ff <= pwdata[8:0];
            REG_CUTOFF:    cut_tgt_ff <= pwdata[13:0];
            REG_RESONANCE: res_tgt_ff <= pwdata[10:0];
            REG_RESPONSE:  rtype_ff   <= pwdata[1:0];
            REG_SMOOTH:    rate_ff    <= pwdata[8:0];
            REG_QUALITY:   qm_ff      <= pwdata[1:0];
            REG_WET:       wet_ff     <= pwdata[8:0];
            REG_RATE:      sr_ff      <= pwdata[17:0];
            default: ;
         endcase
      end
   end

   // ---------------- item front end ----------------
   assign accept    = req_ch.valid && req_ch.ready;
   assign is_sample = (req_ch.mode == MODE_SAMPLE);
   assign hq_now    = !qm_ff[1];
   assign mono_now  = qm_ff[0] || (CHANNELS < 2);
   assign co        = cut_ff[21:8];
   // HQ: co*32768/(2*fs); LQ: (co/2)*32768/fs
   assign div_num   = hq_now ? {co, 14'b0} : {co[13:1], 15'b0};
   assign div_den   = (sr_ff == '0) ? FS_W'(1) : sr_ff;
   assign vol_now   = svol_ff[16:8];
   assign wv_prod   = vol_now * wet_ff;
   assign v2_prod   = vol_now * 9'(9'd256 - wet_ff);
   assign ts_prod   = sr_ff * TICK_RECIP;           // sample_rate / 200
   assign ts_raw    = ts_prod[TICK_SHIFT+10:TICK_SHIFT];

   svfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept && is_sample) state_in = T_TICK;
         T_TICK:  state_in = T_DIV;
         T_DIV:   if (!div_busy) state_in = T_FMUL;
         T_FMUL:  state_in = T_START;
         T_START: state_in = T_RUN;
         T_RUN:   if (!lane_stat[0].busy && (!rsp_valid_ff || rsp_ch.ready))
                     state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == T_IDLE);
      div_start    = (state_ff == T_IDLE) && req_ch.valid && is_sample;
      lane_start   = (state_ff == T_START);
      load_out     = (state_ff == T_RUN) && !lane_stat[0].busy &&
                     (!rsp_valid_ff || rsp_ch.ready);
   end

   // smoothing step toward targets
   assign cnt_next = tick_cnt_ff + 16'd1;
   assign cut_new  = approach(25'(cut_ff), 25'(cut_tgt_ff), 25'(rate_ff) * 25'(CUT_STEP));
   assign reso_new = approach(25'(reso_ff), 25'(res_tgt_ff), 25'(rate_ff) * 25'(RES_STEP));
   assign svol_new = approach(25'(svol_ff), 25'(vol_tgt_ff), 25'({rate_ff, 8'b0}));

   always_comb begin
      cut_in = cut_ff;  reso_in = reso_ff;  svol_in = svol_ff;
      tick_cnt_in = tick_cnt_ff;
      ctl_in = ctl_ff;  mono_in = mono_ff;  xl_in = xl_ff;  xr_in = xr_ff;
      tick_size_in = tick_size_ff;
      fprod_in = fprod_ff;
      if (accept) begin
         if (req_ch.mode == MODE_IMPULSE && req_ch.impulse_cutoff != '0)
            cut_in = {req_ch.impulse_cutoff, 8'b0};
         if (req_ch.mode == MODE_CLEAR) tick_cnt_in = '0;
         if (is_sample) begin
            ctl_in.hq      = hq_now;
            ctl_in.rtype   = rtype_ff;
            ctl_in.f       = '0;
            ctl_in.q       = $signed({1'b0, Q_BASE}) - $signed({1'b0, reso_ff[18:8]});
            ctl_in.wv      = wv_prod[17:8];
            ctl_in.v2      = v2_prod[16:8];
            ctl_in.vol     = vol_now;
            ctl_in.bypass  = (wet_ff == '0);
            ctl_in.partial = (wet_ff < 9'd256);
            mono_in        = mono_now;
            xl_in          = req_ch.left_in;
            xr_in          = req_ch.right_in;
            tick_size_in   = (ts_raw == '0) ? 11'd1 : ts_raw;
         end
      end
      if (state_ff == T_TICK) begin
         if (cnt_next >= 16'(tick_size_ff)) begin
            tick_cnt_in = '0;
            cut_in  = cut_new[21:0];
            reso_in = reso_new[18:0];
            svol_in = svol_new[16:0];
         end else begin
            tick_cnt_in = cnt_next;
         end
      end
      if (state_ff == T_FMUL) fprod_in = div_quo * F_SCALE;
   end

   // f = 6433*c/32768, held below 1024
   always_comb begin
      lane_ctl   = ctl_ff;
      lane_ctl.f = (|fprod_ff[40:25]) ? F_MAX : fprod_ff[24:15];
   end

   // ---------------- filter lanes ----------------
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      svfs_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (lane_start && (i == 0 || !mono_ff)),
         .clear (accept && req_ch.mode == MODE_CLEAR),
         .ctl   (lane_ctl),
         .x     ((i == 0) ? xl_ff : xr_ff),
         .stat  (lane_stat[i])
      );
   end

   // ---------------- merge into result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      lo_in = lo_ff;  ro_in = ro_ff;  rv_in = rv_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         lo_in = lane_stat[0].res;
         ro_in = mono_ff ? 16'sd0 : lane_stat[CHANNELS-1].res;
         rv_in = !mono_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         cut_ff       <= {CUT_STEP, 8'b0};
         reso_ff      <= '0;
         svol_ff      <= 17'd65536;
         tick_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cut_ff       <= cut_in;
         reso_ff      <= reso_in;
         svol_ff      <= svol_in;
         tick_cnt_ff  <= tick_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ctl_ff <= ctl_in;  mono_ff <= mono_in;
      xl_ff <= xl_in;  xr_ff <= xr_in;
      tick_size_ff <= tick_size_in;
      fprod_ff <= fprod_in;
      lo_ff <= lo_in;  ro_ff <= ro_in;  rv_ff <= rv_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.left_out    = lo_ff;
   assign rsp_ch.right_out   = ro_ff;
   assign rsp_ch.right_valid = rv_ff;

   // ---------------- checks ----------------
   `SVFS_ASSERT_NOW(a_lane_idle, state_ff == T_IDLE, !lane_stat[0].busy, "lane busy while idle")
   `SVFS_ASSERT_NOW(a_div_done, state_ff == T_START, !div_busy, "lanes start before f is ready")
   `SVFS_ASSERT_NEXT(a_tick_wrap, state_ff == T_TICK, tick_cnt_ff < 16'(tick_size_ff), "tick count past tick length")
endmodule

@@ dv/svfs_checker.sv @@
`timescale 1ns / 1ps
module svfs_checker import svfs_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic        clock,
   input  logic        reset,
   svfs_req_if         req_mon,
   svfs_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);
   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               rvalid;
   } filt_out_type;

   filt_out_type expected_out_q[$];

   // register copy
   longint tgt_vol, tgt_cut, tgt_res, resp_sel, smooth_rate, qual_mode, wet, fs_reg;
   // filter and smoothing state
   longint band_st[2], low_st[2], prior_st[2];
   longint sm_cut, sm_res, sm_vol;
   longint tick_cnt;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint glide(longint cur, longint tgt, longint step);
      longint nxt;
      nxt = cur;
      if (cur / 256 > tgt) begin
         nxt = cur - step;
         if (nxt < tgt * 256) nxt = tgt * 256;
      end else if (cur / 256 < tgt) begin
         nxt = cur + step;
         if (nxt / 256 > tgt) nxt = tgt * 256;
      end
      return nxt;
   endfunction

   function automatic void clear_stores();
      for (int i = 0; i < 2; i++) begin
         band_st[i] = 0; low_st[i] = 0; prior_st[i] = 0;
      end
      tick_cnt = 0;
   endfunction

   // one channel through the two-integrator loop, returns scaled tap
   function automatic longint lane_run(int ch, longint xin, bit hq, longint rtype,
                                       longint f, longint q, longint gain);
      longint d1, d2, d3, lo, hi, bp, tap, s_lo, s_hi, s_bp, s_nt, x;
      d1 = band_st[ch]; d2 = low_st[ch]; d3 = prior_st[ch];
      x  = xin * 32;
      lo = d2 + (f * d1) / 1024;
      hi = x - lo - (q * d1) / 1024;
      bp = (f * hi) / 1024 + d1;
      if (hq) begin
         s_lo = lo; s_hi = hi; s_bp = bp; s_nt = hi + lo;
         lo = lo + (f * bp) / 1024;
         hi = x - lo - (q * bp) / 1024;
         bp = (f * hi) / 1024 + bp;
         case (rtype)
            RESP_LOW:  tap = ((d2 + s_lo) / 2) / 32;
            RESP_HIGH: begin tap = ((d3 + s_hi) / 2) / 32; d3 = hi; end
            RESP_BAND: tap = ((d1 + s_bp) / 2) / 32;
            default:   begin tap = ((d3 + s_nt) / 2) / 32; d3 = hi + lo; end
         endcase
      end else begin
         case (rtype)
            RESP_LOW:  tap = lo / 32;
            RESP_HIGH: tap = hi / 32;
            RESP_BAND: tap = bp / 32;
            default:   tap = (hi + lo) / 32;
         endcase
      end
      band_st[ch]  = clamp(bp, -64'sd2147483648, 64'sd2147483647);
      low_st[ch]   = clamp(lo, -64'sd2147483648, 64'sd2147483647);
      prior_st[ch] = clamp(d3, -64'sd2147483648, 64'sd2147483647);
      return (tap * gain) / 256;
   endfunction

   // full sample pair: returns the expected result and advances smoothing
   function automatic filt_out_type svf_predict(longint xl, longint xr);
      filt_out_type o;
      bit hq, mono;
      longint fs, c, f, q, vol, wv, w, v2, tsize;
      longint xs[2], res[2];
      hq   = (qual_mode[1] == 1'b0);
      mono = (qual_mode[0] == 1'b1) || (CHANNELS < 2);
      xs[0] = xl; xs[1] = xr; res[0] = 0; res[1] = 0;
      fs = (fs_reg != 0) ? fs_reg : 1;
      if (hq) c = ((sm_cut / 256) * 32768) / (fs * 2);
      else    c = (((sm_cut / 256) / 2) * 32768) / fs;
      f = (6433 * c) / 32768;
      if (f >= 1024) f = 1023;
      q   = 1536 - sm_res / 256;
      vol = sm_vol / 256;
      for (int ch = 0; ch < (mono ? 1 : 2); ch++) begin
         if (wet == 0) begin
            res[ch] = clamp((xs[ch] * vol) / 256, -32768, 32767);
         end else begin
            wv = (vol * wet) / 256;
            w  = clamp(lane_run(ch, xs[ch], hq, resp_sel, f, q, wv), -32768, 32767);
            if (wet < 256) begin
               v2 = (vol * (256 - wet)) / 256;
               w  = clamp(w + (xs[ch] * v2) / 256, -32768, 32767);
            end
            res[ch] = w;
         end
      end
      tsize = fs_reg / 200;
      if (tsize < 1) tsize = 1;
      tick_cnt = (tick_cnt + 1) & 16'hFFFF;
      if (tick_cnt >= tsize) begin
         sm_cut = glide(sm_cut, tgt_cut, smooth_rate * 14000);
         sm_res = glide(sm_res, tgt_res, smooth_rate * 1530);
         sm_vol = glide(sm_vol, tgt_vol, smooth_rate * 256);
         tick_cnt = 0;
      end
      o.left   = res[0][15:0];
      o.right  = mono ? 16'sd0 : res[1][15:0];
      o.rvalid = !mono;
      return o;
   endfunction

   always @(posedge clock) begin
      filt_out_type e;
      if (reset) begin
         tgt_vol = 256; tgt_cut = 14000; tgt_res = 0; resp_sel = 0;
         smooth_rate = 256; qual_mode = 0; wet = 256; fs_reg = 44100;
         sm_cut = 14000 * 256; sm_res = 0; sm_vol = 256 * 256;
         clear_stores();
         expected_out_q.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_VOLUME:    tgt_vol     = pwdata[8:0];
               REG_CUTOFF:    tgt_cut     = pwdata[13:0];
               REG_RESONANCE: tgt_res     = pwdata[10:0];
               REG_RESPONSE:  resp_sel    = pwdata[1:0];
               REG_SMOOTH:    smooth_rate = pwdata[8:0];
               REG_QUALITY:   qual_mode   = pwdata[1:0];
               REG_WET:       wet         = pwdata[8:0];
               REG_RATE:      fs_reg      = pwdata[17:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (expected_out_q.size() == 0) begin
               $display("%0t: unexpected result L=%0d R=%0d", $time,
                        rsp_mon.left_out, rsp_mon.right_out);
               error_count++;
            end else begin
               e = expected_out_q.pop_front();
               if (e.left !== rsp_mon.left_out || e.right !== rsp_mon.right_out ||
                   e.rvalid !== rsp_mon.right_valid) begin
                  $display("%0t: mismatch exp L=%0d R=%0d rv=%0b act L=%0d R=%0d rv=%0b",
                           $time, e.left, e.right, e.rvalid, rsp_mon.left_out,
                           rsp_mon.right_out, rsp_mon.right_valid);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_SAMPLE:
                  expected_out_q.push_back(svf_predict(req_mon.left_in, req_mon.right_in));
               MODE_IMPULSE:
                  if (req_mon.impulse_cutoff != 0) sm_cut = longint'(req_mon.impulse_cutoff) * 256;
               MODE_CLEAR: clear_stores();
               default: ;
            endcase
         end
      end
      pending_count = expected_out_q.size();
   end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import svfs_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;   // ignored by the block
   // quality settings
   localparam logic [1:0] QM_HQ_STEREO = 2'd0;
   localparam logic [1:0] QM_HQ_MONO   = 2'd1;
   localparam logic [1:0] QM_LQ_STEREO = 2'd2;
   localparam logic [1:0] QM_LQ_MONO   = 2'd3;
   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int DRAIN_WAIT  = 60;        // idle margin once all results are out
   localparam int CYCLE_LIMIT = 1000000;

   logic clock, reset;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   int   error_count, pending_count, result_count;
   int   send_idle_pct, recv_stall_pct;
   logic hold_off, start_hold;
   int   cycle_cnt;

   svfs_req_if req_bus();
   svfs_rsp_if rsp_bus();

   state_variable_filter_stereo_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // scoreboard sits beside the block and watches every channel
   svfs_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .error_count(error_count),
      .pending_count(pending_count), .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stalls per phase, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long hold-off: the block fills and must back-pressure its input
   initial begin
      hold_off = 1'b0;
      wait (start_hold);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   // APB write: setup then access; lands at the access edge, bus released by configure
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
   endtask

   // valid stays high across back-to-back items; only lowered when idling
   task automatic send_item(logic [1:0] md, logic [15:0] l, logic [15:0] r, logic [13:0] imp);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= md;
      req_bus.left_in <= l;
      req_bus.right_in <= r;
      req_bus.impulse_cutoff <= imp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80)
         send_item(MODE_SAMPLE, pick_sample(), pick_sample(), 14'($urandom));
      else if (roll < 88)
         send_item(MODE_IMPULSE, 16'($urandom), 16'($urandom),
                   ($urandom_range(5) == 0) ? 14'd0 : 14'($urandom));
      else if (roll < 94)
         send_item(MODE_CLEAR, 16'($urandom), 16'($urandom), 14'($urandom));
      else
         send_item(MODE_UNUSED, 16'($urandom), 16'($urandom), 14'($urandom));
   endtask

   // wait out all results plus a margin so the block is idle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic configure(int ph);
      case (ph)
         0: ;   // reset defaults
         1: begin   // high settings, HQ mono highpass
            csr_write(REG_VOLUME, 256); csr_write(REG_CUTOFF, 14000);
            csr_write(REG_RESONANCE, 1530); csr_write(REG_RESPONSE, RESP_HIGH);
            csr_write(REG_SMOOTH, 256); csr_write(REG_QUALITY, QM_HQ_MONO);
            csr_write(REG_WET, 256); csr_write(REG_RATE, 192000);
         end
         2: begin   // lower extremes (rate apart), bypass
            csr_write(REG_VOLUME, 0); csr_write(REG_CUTOFF, 0);
            csr_write(REG_RESONANCE, 0); csr_write(REG_RESPONSE, RESP_BAND);
            csr_write(REG_SMOOTH, 0); csr_write(REG_QUALITY, QM_LQ_STEREO);
            csr_write(REG_WET, 0); csr_write(REG_RATE, 8000);
         end
         3: begin   // zero rate, wet over unity, negative damping, notch
            csr_write(REG_VOLUME, 200); csr_write(REG_CUTOFF, 3000);
            csr_write(REG_RESONANCE, 2000); csr_write(REG_RESPONSE, RESP_NOTCH);
            csr_write(REG_SMOOTH, 3); csr_write(REG_QUALITY, QM_LQ_MONO);
            csr_write(REG_WET, 300); csr_write(REG_RATE, 0);
         end
         default: begin   // random values within the field widths, wet always a partial mix
            csr_write(REG_VOLUME, $urandom_range(511));
            csr_write(REG_CUTOFF, $urandom_range(16383));
            csr_write(REG_RESONANCE, $urandom_range(2047));
            csr_write(REG_RESPONSE, $urandom_range(3));
            csr_write(REG_SMOOTH, $urandom_range(511));
            csr_write(REG_QUALITY, (ph == 4) ? QM_HQ_STEREO : $urandom_range(3));
            csr_write(REG_WET, $urandom_range(1, 255));
            csr_write(REG_RATE, ($urandom_range(3) == 0) ? $urandom_range(2000)
                                                          : $urandom_range(8000, 262143));
         end
      endcase
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   initial begin
      cycle_cnt = 0;
      start_hold = 1'b0;
      send_idle_pct = 0; recv_stall_pct = 0;
      reset <= 1'b1;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
      req_bus.valid <= 1'b0; req_bus.mode <= MODE_SAMPLE;
      req_bus.left_in <= '0; req_bus.right_in <= '0; req_bus.impulse_cutoff <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         configure(ph);
         // idle pattern rotates: none, sender idle, receiver stall, both light
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (ph == 0) begin
            // directed: field extremes, every mode, impulse of zero
            send_item(MODE_SAMPLE, 16'h7FFF, 16'h8000, 14'd0);
            send_item(MODE_SAMPLE, 16'h8000, 16'h7FFF, 14'h3FFF);
            send_item(MODE_SAMPLE, 16'h0000, 16'hFFFF, 14'd0);
            send_item(MODE_IMPULSE, 16'h0, 16'h0, 14'd0);
            send_item(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 14'd0);
            send_item(MODE_IMPULSE, 16'h0, 16'h0, 14'd500);
            send_item(MODE_SAMPLE, 16'h8000, 16'h8000, 14'd0);
            send_item(MODE_SAMPLE, 16'h1234, 16'hEDCB, 14'd0);
            send_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 14'h3FFF);
            send_item(MODE_SAMPLE, 16'h4000, 16'hC000, 14'd0);
            send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 14'h3FFF);
            send_item(MODE_IMPULSE, 16'h0, 16'h0, 14'd14000);
            send_item(MODE_SAMPLE, 16'h0001, 16'hFFFE, 14'd0);
         end
         if (ph == 1) start_hold = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_random();
         drain();
      end

      $display("Ran %0d config phases, %0d filtered results checked", N_PHASES, result_count);
      $display("Covered all responses, HQ/LQ stereo/mono, bypass and partial mix, stalls");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
